FILE: hw/rtl/skqt_pkg.sv
package skqt_pkg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_APPLY
    } state_t;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_UPDATE = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    localparam int QTY_BITS = 32;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic look;  // compare stored key with the request key
        logic ins;   // open a gap and place the new entry
        logic upd;   // rewrite the quantity of the matching cell
    } cell_ctl_t;

endpackage

FILE: hw/rtl/skqt_cell.sv
module skqt_cell #(
    parameter int IDX      = 0,
    parameter int KEY_BITS = 16,
    parameter int CNT_W    = 7
) (
    input  logic                                clk,
    input  skqt_pkg::cell_ctl_t                 ctl,
    input  logic [CNT_W-1:0]                    cnt,
    input  logic [KEY_BITS-1:0]                 req_key,
    input  logic signed [skqt_pkg::QTY_BITS-1:0] new_qty,
    input  logic                                prev_lt,
    input  logic [KEY_BITS-1:0]                 left_key,
    input  logic signed [skqt_pkg::QTY_BITS-1:0] left_qty,
    output logic [KEY_BITS-1:0]                 key,
    output logic signed [skqt_pkg::QTY_BITS-1:0] qty,
    output logic                                lt,
    output logic                                eq,
    output logic signed [skqt_pkg::QTY_BITS-1:0] hit_qty
);

    logic [KEY_BITS-1:0]                  key_reg;
    logic signed [skqt_pkg::QTY_BITS-1:0] qty_reg;
    logic                                 lt_reg;
    logic                                 eq_reg;
    logic                                 occupied;

    // a cell holds a live entry when its position is below the fill count
    assign occupied = (cnt > CNT_W'(IDX));

    always_ff @(posedge clk)
    begin
        if (ctl.look)
        begin
            lt_reg <= occupied && (key_reg < req_key);
            eq_reg <= occupied && (key_reg == req_key);
        end
        if (ctl.ins && !lt_reg)
        begin
            // first cell at or above the new key takes it, the rest shift up
            key_reg <= prev_lt ? req_key : left_key;
            qty_reg <= prev_lt ? new_qty : left_qty;
        end
        else if (ctl.upd && eq_reg)
        begin
            qty_reg <= new_qty;
        end
    end

    assign key     = key_reg;
    assign qty     = qty_reg;
    assign lt      = lt_reg;
    assign eq      = eq_reg;
    assign hit_qty = eq_reg ? qty_reg : '0;

endmodule

FILE: hw/rtl/skqt_reduce.sv
module skqt_reduce #(
    parameter int CAPACITY = 64
) (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic [CAPACITY-1:0]                  hit,
    input  logic [skqt_pkg::QTY_BITS-1:0]        hit_qty [CAPACITY],
    output logic                                 found,
    output logic signed [skqt_pkg::QTY_BITS-1:0] found_qty
);

    logic                                 found_reg;
    logic [skqt_pkg::QTY_BITS-1:0]        qty_reg;
    logic [skqt_pkg::QTY_BITS-1:0]        qty_or;

    // at most one cell matches, so an OR over the masked quantities selects it
    always_comb
    begin
        qty_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            qty_or = qty_or | hit_qty[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            found_reg <= |hit;
            qty_reg   <= qty_or;
        end
    end

    assign found     = found_reg;
    assign found_qty = qty_reg;

endmodule

FILE: hw/rtl/sorted_key_quantity_table.sv
// Channel   Dir  Fields (tdata / tuser, low bit first)
// s_axis    in   tdata: part_key[15:0], amount[31:0]   tuser: kind[1:0]
// m_axis    out  tdata: status[1:0], quantity_out[31:0], 6 zero bits
//
// A request passes through the accept beat, a compare in every cell,
// an OR reduction of the matching cell's quantity, and the commit.
// The commit waits while the previous result still sits in the output register;
// a new request is taken while a finished result waits to be drained.
// Reset clears the fill count and the control state; the cells keep no reset,
// a cell at or beyond the fill count is treated as empty.
module sorted_key_quantity_table #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // part_key[15:0], amount[31:0]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status[1:0], quantity_out[31:0], zero pad
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int QB    = skqt_pkg::QTY_BITS;

    skqt_pkg::state_t state_reg, state_next;

    // request held for the whole operation
    logic [1:0]          kind_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic signed [QB-1:0] amount_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg, m_data_next;

    logic accept;
    logic out_free;
    logic go;

    skqt_pkg::cell_ctl_t ctl;
    logic signed [QB-1:0] new_qty;

    logic [KEY_BITS-1:0]  key_arr [CAPACITY];
    logic signed [QB-1:0] qty_arr [CAPACITY];
    logic [QB-1:0]        hit_arr [CAPACITY];
    logic [CAPACITY-1:0]  lt_vec;
    logic [CAPACITY-1:0]  eq_vec;

    logic                 found;
    logic signed [QB-1:0] found_qty;

    logic signed [QB:0]   sum;
    logic signed [QB-1:0] sat_sum;
    skqt_pkg::status_t    status;
    logic signed [QB-1:0] result_qty;
    logic                 do_ins;
    logic                 do_upd;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign go       = (state_reg == skqt_pkg::S_APPLY) && out_free;

    // -------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skqt_pkg::S_IDLE:  if (s_tvalid) state_next = skqt_pkg::S_LOOK;
            skqt_pkg::S_LOOK:  state_next = skqt_pkg::S_SCAN;
            skqt_pkg::S_SCAN:  state_next = skqt_pkg::S_APPLY;
            skqt_pkg::S_APPLY: if (out_free) state_next = skqt_pkg::S_IDLE;
            default:           state_next = skqt_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        ctl      = '0;
        unique case (state_reg)
            skqt_pkg::S_IDLE:  s_tready = 1'b1;
            skqt_pkg::S_LOOK:  ctl.look = 1'b1;
            skqt_pkg::S_SCAN:  ctl      = '0;
            skqt_pkg::S_APPLY:
            begin
                ctl.ins = go && do_ins;
                ctl.upd = go && do_upd;
            end
            default:           ctl      = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= skqt_pkg::S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= s_tuser;
            key_reg    <= KEY_BITS'(s_tdata[15:0]);   // keep the low KEY_BITS bits
            amount_reg <= s_tdata[47:16];
        end
        m_data_reg <= m_data_next;
    end

    // -------------------------------------------------------------- cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                 prev_lt;
        logic [KEY_BITS-1:0]  left_key;
        logic signed [QB-1:0] left_qty;

        if (i == 0)
        begin : g_head
            assign prev_lt  = 1'b1;
            assign left_key = '0;
            assign left_qty = '0;
        end
        else
        begin : g_body
            assign prev_lt  = lt_vec[i-1];
            assign left_key = key_arr[i-1];
            assign left_qty = qty_arr[i-1];
        end

        skqt_cell #(
            .IDX      (i),
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .cnt      (cnt_reg),
            .req_key  (key_reg),
            .new_qty  (new_qty),
            .prev_lt  (prev_lt),
            .left_key (left_key),
            .left_qty (left_qty),
            .key      (key_arr[i]),
            .qty      (qty_arr[i]),
            .lt       (lt_vec[i]),
            .eq       (eq_vec[i]),
            .hit_qty  (hit_arr[i])
        );
    end

    skqt_reduce #(
        .CAPACITY (CAPACITY)
    ) u_reduce (
        .clk       (clk),
        .load      (state_reg == skqt_pkg::S_SCAN),
        .hit       (eq_vec),
        .hit_qty   (hit_arr),
        .found     (found),
        .found_qty (found_qty)
    );

    // -------------------------------------------------------------- commit
    // saturate the update at the signed 32-bit limits
    assign sum = {found_qty[QB-1], found_qty} + {amount_reg[QB-1], amount_reg};

    always_comb
    begin
        if (sum[QB] != sum[QB-1])
            sat_sum = sum[QB] ? {1'b1, {(QB-1){1'b0}}} : {1'b0, {(QB-1){1'b1}}};
        else
            sat_sum = sum[QB-1:0];
    end

    always_comb
    begin
        status     = skqt_pkg::ST_MISSING;
        result_qty = '0;
        do_ins     = 1'b0;
        do_upd     = 1'b0;
        new_qty    = amount_reg;
        case (kind_reg)
            skqt_pkg::KIND_INSERT:
            begin
                // a full table reports full even for a key already present
                if (cnt_reg == CNT_W'(CAPACITY))
                    status = skqt_pkg::ST_FULL;
                else if (found)
                    status = skqt_pkg::ST_DUP;
                else
                begin
                    status     = skqt_pkg::ST_OK;
                    result_qty = amount_reg;
                    do_ins     = 1'b1;
                end
            end
            skqt_pkg::KIND_SEARCH:
            begin
                if (found)
                begin
                    status     = skqt_pkg::ST_OK;
                    result_qty = found_qty;
                end
            end
            skqt_pkg::KIND_UPDATE:
            begin
                new_qty = sat_sum;
                if (found)
                begin
                    status     = skqt_pkg::ST_OK;
                    result_qty = sat_sum;
                    do_upd     = 1'b1;
                end
            end
            default:
            begin
                status = skqt_pkg::ST_MISSING;
            end
        endcase
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_tready)
            m_valid_next = 1'b0;
        if (go)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {6'd0, result_qty, status};
            if (do_ins)
                cnt_next = cnt_reg + 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // -------------------------------------------------------------- checks
    a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == skqt_pkg::S_APPLY |-> $onehot0(eq_vec))
        else $error("more than one cell matches the request key");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.ins |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("insert did not advance the fill count");

    a_commit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> m_tvalid)
        else $error("commit did not present a result");

endmodule

FILE: sim/sorted_key_quantity_table_test.sv
module sorted_key_quantity_table_test;

    localparam int CAPACITY    = 64;
    localparam int KEY_BITS    = 16;
    localparam int RANDOM_REQS = 1430;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 16;

    localparam logic signed [31:0] QTY_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;

    // one reply beat as the table should produce it
    typedef struct {
        skqt_pkg::status_t  status;
        logic signed [31:0] quantity;
    } table_reply_t;

    // one row of the directed part; typed = 1 means the reply is given in the row
    typedef struct packed {
        skqt_pkg::kind_t    kind;
        logic [15:0]        key;
        logic signed [31:0] amount;
        logic               typed;
        skqt_pkg::status_t  status;
        logic signed [31:0] quantity;
    } request_row_t;

    localparam int N_DIRECTED = 20;
    localparam request_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // empty table: every lookup misses, the unused kind misses too
        '{skqt_pkg::KIND_SEARCH, 16'h1234, 32'sd0,  1'b1, skqt_pkg::ST_MISSING, 32'sd0},
        '{skqt_pkg::KIND_UPDATE, 16'h1234, 32'sd5,  1'b1, skqt_pkg::ST_MISSING, 32'sd0},
        '{skqt_pkg::KIND_UNUSED, 16'h0000, 32'sd0,  1'b1, skqt_pkg::ST_MISSING, 32'sd0},
        // lowest key with the most negative quantity, then a duplicate
        '{skqt_pkg::KIND_INSERT, 16'h0000, QTY_MIN, 1'b1, skqt_pkg::ST_OK,      QTY_MIN},
        '{skqt_pkg::KIND_INSERT, 16'h0000, 32'sd7,  1'b1, skqt_pkg::ST_DUP,     32'sd0},
        // saturate low
        '{skqt_pkg::KIND_UPDATE, 16'h0000, -32'sd1, 1'b1, skqt_pkg::ST_OK,      QTY_MIN},
        // highest key with the largest quantity, saturate high
        '{skqt_pkg::KIND_INSERT, 16'hFFFF, QTY_MAX, 1'b1, skqt_pkg::ST_OK,      QTY_MAX},
        '{skqt_pkg::KIND_UPDATE, 16'hFFFF, 32'sd1,  1'b1, skqt_pkg::ST_OK,      QTY_MAX},
        '{skqt_pkg::KIND_UPDATE, 16'hFFFF, QTY_MIN, 1'b1, skqt_pkg::ST_OK,      -32'sd1},
        '{skqt_pkg::KIND_INSERT, 16'h8000, 32'sd0,  1'b1, skqt_pkg::ST_OK,      32'sd0},
        '{skqt_pkg::KIND_SEARCH, 16'h8000, 32'sd0,  1'b1, skqt_pkg::ST_OK,      32'sd0},
        // alternating bit patterns in the amount, keys inserted out of order
        '{skqt_pkg::KIND_INSERT, 16'h7FFF, 32'sh5555_5555, 1'b0, skqt_pkg::ST_OK, 32'sd0},
        '{skqt_pkg::KIND_INSERT, 16'h0001, 32'shAAAA_AAAA, 1'b0, skqt_pkg::ST_OK, 32'sd0},
        '{skqt_pkg::KIND_UPDATE, 16'h7FFF, 32'sh2AAA_AAAA, 1'b0, skqt_pkg::ST_OK, 32'sd0},
        '{skqt_pkg::KIND_SEARCH, 16'h0001, 32'sh1234_5678, 1'b0, skqt_pkg::ST_OK, 32'sd0},
        // gap between stored keys
        '{skqt_pkg::KIND_SEARCH, 16'h0002, 32'sd0,  1'b1, skqt_pkg::ST_MISSING, 32'sd0},
        // unused kind on a stored key leaves it alone
        '{skqt_pkg::KIND_UNUSED, 16'hFFFF, 32'sd99, 1'b1, skqt_pkg::ST_MISSING, 32'sd0},
        '{skqt_pkg::KIND_UPDATE, 16'h0000, QTY_MAX, 1'b0, skqt_pkg::ST_OK,      32'sd0},
        '{skqt_pkg::KIND_SEARCH, 16'hFFFF, 32'sd0,  1'b0, skqt_pkg::ST_OK,      32'sd0},
        '{skqt_pkg::KIND_INSERT, 16'h4000, -32'sd5, 1'b0, skqt_pkg::ST_OK,      32'sd0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // part_key[15:0], amount[31:0]
    logic [1:0]  s_tuser;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // status[1:0], quantity_out[31:0], zero pad

    // shadow of the table, kept sorted by key
    logic [15:0]        shadow_keys[$];
    logic signed [31:0] shadow_qty[$];

    table_reply_t pending_replies[$];

    int send_idle_pct;
    int ready_stall_pct;
    int failures    = 0;
    int cycle_count = 0;

    sorted_key_quantity_table #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one request to the shadow table and return the reply it earns.
    function automatic table_reply_t apply_request(skqt_pkg::kind_t kind,
                                                   logic [15:0] key,
                                                   logic signed [31:0] amount);
        table_reply_t       reply;
        int                 pos;
        bit                 hit;
        logic signed [63:0] sum;
        reply.status   = skqt_pkg::ST_MISSING;
        reply.quantity = 32'sd0;
        pos = 0;
        while (pos < shadow_keys.size() && shadow_keys[pos] < key)
            pos++;
        hit = (pos < shadow_keys.size()) && (shadow_keys[pos] == key);
        case (kind)
            skqt_pkg::KIND_INSERT:
            begin
                // a full table refuses before the duplicate test
                if (shadow_keys.size() >= CAPACITY)
                    reply.status = skqt_pkg::ST_FULL;
                else if (hit)
                    reply.status = skqt_pkg::ST_DUP;
                else
                begin
                    shadow_keys.insert(pos, key);
                    shadow_qty.insert(pos, amount);
                    reply.status   = skqt_pkg::ST_OK;
                    reply.quantity = amount;
                end
            end
            skqt_pkg::KIND_SEARCH:
            begin
                if (hit)
                begin
                    reply.status   = skqt_pkg::ST_OK;
                    reply.quantity = shadow_qty[pos];
                end
            end
            skqt_pkg::KIND_UPDATE:
            begin
                if (hit)
                begin
                    sum = shadow_qty[pos] + amount;
                    if (sum > 64'sd2147483647)
                        sum = 64'sd2147483647;
                    if (sum < -64'sd2147483648)
                        sum = -64'sd2147483648;
                    shadow_qty[pos] = sum[31:0];
                    reply.status    = skqt_pkg::ST_OK;
                    reply.quantity  = sum[31:0];
                end
            end
            default:
                ;
        endcase
        return reply;
    endfunction

    // Present one request beat, hold it until accepted, then log its reply.
    // Leave tvalid high afterwards; the next call lowers it only for a gap.
    task automatic send_request(skqt_pkg::kind_t kind, logic [15:0] key,
                                logic signed [31:0] amount,
                                bit typed, table_reply_t typed_reply);
        table_reply_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {amount, key};
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_request(kind, key, amount);
        if (typed)
            pending_replies.push_back(typed_reply);
        else
            pending_replies.push_back(predicted);
    endtask

    // Hold off until every logged reply has been drained.
    task automatic wait_drained();
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: check each accepted reply beat, then pick the next tready.
    always @(posedge clk)
    begin
        table_reply_t      want;
        skqt_pkg::status_t got_status;
        logic [31:0]       got_qty;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_status = skqt_pkg::status_t'(m_tdata[1:0]);
            got_qty    = m_tdata[33:2];
            if (pending_replies.size() == 0)
            begin
                $error("reply beat with nothing pending: status %0d quantity %0d",
                       got_status, $signed(got_qty));
                failures++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got_status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    failures++;
                end
                if (got_qty !== want.quantity)
                begin
                    $error("quantity_out: expected %0d, got %0d",
                           want.quantity, $signed(got_qty));
                    failures++;
                end
                if (m_tdata[39:34] !== 6'd0)
                begin
                    $error("pad: expected 0, got %0h", m_tdata[39:34]);
                    failures++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // Watchdog: bail out if the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        table_reply_t       typed_reply;
        skqt_pkg::kind_t    kind;
        logic [15:0]        key;
        logic signed [31:0] amount;
        int                 pick;
        int                 phase;
        send_idle_pct   = 8;
        ready_stall_pct = 65;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: extremes, every kind, the lowest and highest keys
        for (int i = 0; i < N_DIRECTED; i++)
        begin
            typed_reply.status   = DIRECTED_ROWS[i].status;
            typed_reply.quantity = DIRECTED_ROWS[i].quantity;
            send_request(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].key,
                         DIRECTED_ROWS[i].amount, DIRECTED_ROWS[i].typed, typed_reply);
        end

        // starve the block once: drop tvalid until every reply is back
        s_tvalid <= 1'b0;
        wait_drained();

        // random part in three idle phases; the table fills up during the first
        typed_reply.status   = skqt_pkg::ST_OK;
        typed_reply.quantity = 32'sd0;
        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            phase = n * 3 / RANDOM_REQS;
            send_idle_pct   = (phase == 0) ? 8 : (phase == 1) ? 65 : 0;
            ready_stall_pct = (phase == 0) ? 65 : (phase == 1) ? 8 : 0;

            pick = $urandom_range(99);
            kind = (pick < 30) ? skqt_pkg::KIND_INSERT :
                   (pick < 60) ? skqt_pkg::KIND_SEARCH :
                   (pick < 93) ? skqt_pkg::KIND_UPDATE : skqt_pkg::KIND_UNUSED;

            // aim mostly at stored keys for lookups, mostly at fresh keys for inserts
            pick = $urandom_range(99);
            if (shadow_keys.size() != 0 &&
                ((kind == skqt_pkg::KIND_INSERT) ? (pick < 20) : (pick < 80)))
                key = shadow_keys[$urandom_range(shadow_keys.size() - 1)];
            else
                key = 16'($urandom_range(16'hFFFF));

            // lean on the limits so updates saturate often
            pick = $urandom_range(99);
            if (pick < 8)
                amount = QTY_MAX;
            else if (pick < 16)
                amount = QTY_MIN;
            else if (pick < 30)
                amount = $signed(32'($urandom_range(200))) - 32'sd100;
            else
                amount = $urandom;

            send_request(kind, key, amount, 1'b0, typed_reply);
        end
        s_tvalid <= 1'b0;

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/skqt_pkg.sv
hw/rtl/skqt_cell.sv
hw/rtl/skqt_reduce.sv
hw/rtl/sorted_key_quantity_table.sv
sim/sorted_key_quantity_table_test.sv
